>>> src/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants for the deadline-first task scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = SLOT_W + 1;
	localparam int TIME_W = 32;

	localparam logic [1:0] FN_TICK   = 2'd0;
	localparam logic [1:0] FN_BG     = 2'd1;
	localparam logic [1:0] FN_RT     = 2'd2;
	localparam logic [1:0] FN_SELECT = 2'd3;

	localparam logic [1:0] STS_DONE = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_NONE = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [TIME_W-1:0] start_offset_ms;
		logic [TIME_W-1:0] relative_deadline_ms;
		logic              current_still_runnable;
	} in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] task_id;
		logic              task_is_realtime;
		logic              waited;
		logic [TIME_W-1:0] time_ms;
		logic [31:0]       deadlines_met;
		logic [31:0]       deadlines_missed;
	} out_t;

	// one real-time task in the deadline list
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] start_ms;
		logic [TIME_W-1:0] deadline;
	} dl_entry_t;

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [SLOT_W-1:0] rem_idx;
	} chain_cmd_t;

	typedef struct packed {
		logic ins;
		logic rem;
		logic take_next;
		logic prev_keep;
	} cell_ctl_t;

endpackage

>>> src/edf_cell.sv
// ----------------------------------------------------------------------------
// edf_cell
// One place of the deadline-sorted list: shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
module edf_cell import edf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  dl_entry_t         ins_entry,
	input  dl_entry_t         prev_entry,
	input  dl_entry_t         next_entry,
	input  logic [TIME_W-1:0] clock_ms,
	output dl_entry_t         entry,
	output logic              keep,
	output logic              released
);

	logic              valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] release_q;
	logic [TIME_W-1:0] deadline_q;
	dl_entry_t         nxt;
	logic              load;

	assign entry    = '{valid: valid_q, slot: slot_q, start_ms: release_q, deadline: deadline_q};
	// equal deadlines stay ahead of the new one
	assign keep     = valid_q && (deadline_q <= ins_entry.deadline);
	assign released = valid_q && (release_q <= clock_ms);

	always_comb begin
		nxt  = entry;
		load = 1'b0;
		if (ctl.ins && !keep) begin
			load = 1'b1;
			nxt  = ctl.prev_keep ? ins_entry : prev_entry;
		end else if (ctl.rem && ctl.take_next) begin
			load = 1'b1;
			nxt  = next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q     <= nxt.slot;
			release_q  <= nxt.start_ms;
			deadline_q <= nxt.deadline;
		end
	end

endmodule

>>> src/edf_chain.sv
// ----------------------------------------------------------------------------
// edf_chain
// Row of list cells holding real-time tasks in deadline order.
// ----------------------------------------------------------------------------
module edf_chain import edf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  chain_cmd_t        cmd,
	input  dl_entry_t         ins_entry,
	input  logic [TIME_W-1:0] clock_ms,
	input  logic [SLOT_W-1:0] rd_idx,
	output dl_entry_t         rd_entry,
	output logic              rel_any,
	output dl_entry_t         rel_entry,
	output logic [SLOT_W-1:0] rel_idx,
	output logic              head_valid
);

	dl_entry_t cells [SLOTS];
	logic      keep  [SLOTS];
	logic [SLOTS-1:0] rel_vec;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		cell_ctl_t ctl;
		dl_entry_t prev_e;
		dl_entry_t next_e;
		logic      rel;

		if (i == 0) begin : g_first
			assign prev_e        = '0;
			assign ctl.prev_keep = 1'b1;
		end else begin : g_mid
			assign prev_e        = cells[i-1];
			assign ctl.prev_keep = keep[i-1];
		end
		if (i == SLOTS-1) begin : g_last
			assign next_e = '0;
		end else begin : g_nlast
			assign next_e = cells[i+1];
		end
		assign ctl.ins       = cmd.ins;
		assign ctl.rem       = cmd.rem;
		assign ctl.take_next = (SLOT_W'(i) >= cmd.rem_idx);
		assign rel_vec[i]    = rel;

		edf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.ins_entry (ins_entry),
			.prev_entry(prev_e),
			.next_entry(next_e),
			.clock_ms  (clock_ms),
			.entry     (cells[i]),
			.keep      (keep[i]),
			.released  (rel)
		);
	end

	// first released task in deadline order
	always_comb begin
		rel_idx = '0;
		for (int i = SLOTS-1; i >= 0; i--) begin
			if (rel_vec[i]) begin
				rel_idx = SLOT_W'(i);
			end
		end
	end

	assign rel_any    = |rel_vec;
	assign rel_entry  = cells[rel_idx];
	assign rd_entry   = cells[rd_idx];
	assign head_valid = cells[0].valid;

endmodule

>>> src/edf_realtime_task_scheduler.sv
// ----------------------------------------------------------------------------
// edf_realtime_task_scheduler
// Deadline-first task scheduler with a background FIFO and a sorted task list.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with an in_t payload; each gives exactly
// one out_t result on out_valid/out_ready. One request is worked on at a time.
// From the accepting edge, tick, background create and a refused create go
// straight to the result state; real-time create computes release, then
// deadline, then inserts; select runs SEL0, RQ after a real-time requeue, then
// SEL1. When the clock must jump to the earliest release, select scans the list
// and warps the clock before SEL1 again. in_ready returns as the result is
// registered; the scan of the list cells, one cell a cycle, sets the worst case.
// A finished result sits in the output register until taken; while it waits the
// block holds its next result back and stops accepting only once that result is
// ready, so a stalled receiver costs nothing until then.
// Reset clears the clock, counters, slot table, FIFO and list: no task exists
// and none runs. Nothing is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module edf_realtime_task_scheduler import edf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CREL = 4'd1;
	localparam logic [3:0] ST_CDL  = 4'd2;
	localparam logic [3:0] ST_CINS = 4'd3;
	localparam logic [3:0] ST_SEL0 = 4'd4;
	localparam logic [3:0] ST_RQ   = 4'd5;
	localparam logic [3:0] ST_SEL1 = 4'd6;
	localparam logic [3:0] ST_SCAN = 4'd7;
	localparam logic [3:0] ST_WARP = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0]        state_q;
	logic [TIME_W-1:0] clock_q;
	logic [31:0]       met_q, miss_q;
	logic [SLOTS-1:0]  used_q, slot_rt_q;
	logic [SLOT_W-1:0] fifo_q [SLOTS];
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_valid_q;
	dl_entry_t         run_q;
	dl_entry_t         ins_q;
	in_t               req_q;
	logic [1:0]        res_status_q;
	logic [SLOT_W-1:0] res_id_q;
	logic              res_rt_q, wait_q;
	logic [SLOT_W-1:0] idx_q;
	logic [TIME_W-1:0] min_q;
	logic              out_valid_q;
	out_t              out_q;

	logic              free_any;
	logic [SLOT_W-1:0] free_idx;
	chain_cmd_t        cmd;
	dl_entry_t         rd_entry, rel_entry;
	logic              rel_any, head_valid;
	logic [SLOT_W-1:0] rel_idx;
	logic              accept, emit;
	logic [SLOT_W-1:0] tail;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign emit      = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign tail      = head_q + cnt_q[SLOT_W-1:0];

	// lowest free slot
	always_comb begin
		free_any = ~&used_q;
		free_idx = '0;
		for (int i = SLOTS-1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.ins = (state_q == ST_CINS) || (state_q == ST_RQ);
		if (state_q == ST_SEL1 && head_valid && rel_any) begin
			cmd.rem     = 1'b1;
			cmd.rem_idx = rel_idx;
		end
	end

	edf_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ins_entry (ins_q),
		.clock_ms  (clock_q),
		.rd_idx    (idx_q),
		.rd_entry  (rd_entry),
		.rel_any   (rel_any),
		.rel_entry (rel_entry),
		.rel_idx   (rel_idx),
		.head_valid(head_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clock_q     <= '0;
			met_q       <= '0;
			miss_q      <= '0;
			used_q      <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			run_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.func)
							FN_TICK: begin
								clock_q <= clock_q + 1'b1;
								state_q <= ST_DONE;
							end
							FN_BG, FN_RT: begin
								if (!free_any) begin
									state_q <= ST_DONE;
								end else begin
									used_q[free_idx] <= 1'b1;
									if (in_data.func == FN_BG) begin
										cnt_q   <= cnt_q + 1'b1;
										state_q <= ST_DONE;
									end else begin
										state_q <= ST_CREL;
									end
								end
							end
							default: state_q <= ST_SEL0;
						endcase
					end
				end
				ST_CREL: state_q <= ST_CDL;
				ST_CDL:  state_q <= ST_CINS;
				ST_CINS: state_q <= ST_DONE;
				ST_SEL0: begin
					state_q <= ST_SEL1;
					if (run_valid_q) begin
						if (req_q.current_still_runnable) begin
							if (slot_rt_q[run_q.slot]) begin
								state_q <= ST_RQ;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end else begin
							if (slot_rt_q[run_q.slot]) begin
								if (clock_q > run_q.deadline) begin
									miss_q <= miss_q + 1'b1;
								end else begin
									met_q <= met_q + 1'b1;
								end
							end
							used_q[run_q.slot] <= 1'b0;
						end
					end
					run_valid_q <= 1'b0;
				end
				ST_RQ: state_q <= ST_SEL1;
				ST_SEL1: begin
					state_q <= ST_DONE;
					if (head_valid && rel_any) begin
						run_valid_q <= 1'b1;
					end else if (cnt_q != '0) begin
						run_valid_q <= 1'b1;
						head_q      <= head_q + 1'b1;
						cnt_q       <= cnt_q - 1'b1;
					end else if (head_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == SLOT_W'(SLOTS-1) || !rd_entry.valid) begin
						state_q <= ST_WARP;
					end
				end
				ST_WARP: begin
					if (clock_q < min_q) begin
						clock_q <= min_q;
					end
					state_q <= ST_SEL1;
				end
				ST_DONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q        <= in_data;
				res_status_q <= STS_DONE;
				res_id_q     <= '0;
				res_rt_q     <= 1'b0;
				wait_q       <= 1'b0;
				if (accept && (in_data.func == FN_BG || in_data.func == FN_RT)) begin
					if (!free_any) begin
						res_status_q <= STS_FULL;
					end else begin
						res_id_q            <= free_idx;
						slot_rt_q[free_idx] <= (in_data.func == FN_RT);
						res_rt_q            <= (in_data.func == FN_RT);
						ins_q.valid         <= 1'b1;
						ins_q.slot          <= free_idx;
						if (in_data.func == FN_BG) begin
							fifo_q[tail] <= free_idx;
						end
					end
				end
			end
			ST_CREL: ins_q.start_ms <= clock_q + req_q.start_offset_ms;
			ST_CDL:  ins_q.deadline <= ins_q.start_ms + req_q.relative_deadline_ms;
			ST_SEL0: begin
				// a real-time task always came from the list, so run_q is complete
				ins_q <= run_q;
				if (run_valid_q && req_q.current_still_runnable
					&& !slot_rt_q[run_q.slot]) begin
					fifo_q[tail] <= run_q.slot;
				end
			end
			ST_SEL1: begin
				idx_q <= '0;
				if (head_valid && rel_any) begin
					run_q    <= rel_entry;
					res_id_q <= rel_entry.slot;
					res_rt_q <= slot_rt_q[rel_entry.slot];
				end else if (cnt_q != '0) begin
					run_q.slot <= fifo_q[head_q];
					res_id_q   <= fifo_q[head_q];
					res_rt_q   <= slot_rt_q[fifo_q[head_q]];
				end else if (!head_valid) begin
					res_status_q <= STS_NONE;
				end
			end
			ST_SCAN: begin
				if (rd_entry.valid && (idx_q == '0 || rd_entry.start_ms < min_q)) begin
					min_q <= rd_entry.start_ms;
				end
				idx_q <= idx_q + 1'b1;
			end
			ST_WARP: begin
				if (clock_q < min_q) begin
					wait_q <= 1'b1;
				end
			end
			ST_DONE: begin
				if (emit) begin
					out_q.status           <= res_status_q;
					out_q.task_id          <= res_id_q;
					out_q.task_is_realtime <= res_rt_q;
					out_q.waited           <= wait_q;
					out_q.time_ms          <= clock_q;
					out_q.deadlines_met    <= met_q;
					out_q.deadlines_missed <= miss_q;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> src/edf_checker.sv
// ----------------------------------------------------------------------------
// edf_checker
// Port-level checks on the scheduler results.
// ----------------------------------------------------------------------------
module edf_checker import edf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// refused create reports no task
	a_full_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STS_FULL |->
			out_data.task_id == '0 && !out_data.task_is_realtime && !out_data.waited)
		else $error("refused create reports a task");

	// idle select reports no task
	a_none_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STS_NONE |->
			out_data.task_id == '0 && !out_data.task_is_realtime)
		else $error("empty select reports a task");

	// a clock jump always hands out a real-time task
	a_wait_rt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.waited |->
			out_data.status == STS_DONE && out_data.task_is_realtime)
		else $error("clock jump without real-time pick");

endmodule

bind edf_realtime_task_scheduler edf_checker u_edf_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the deadline-first scheduler against a behavioral model of its slot
// table, background queue and deadline list, using directed and random requests.
// ----------------------------------------------------------------------------
module tb_top;
	import edf_pkg::*;

	localparam int RAND_REQS = 540;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	edf_realtime_task_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// scheduler model state
	logic [TIME_W-1:0] m_clock;
	logic [SLOT_W-1:0] m_run_slot;
	logic              m_run_valid;
	logic              m_used [SLOTS];
	logic              m_rt [SLOTS];
	logic [TIME_W-1:0] m_release [SLOTS];
	logic [TIME_W-1:0] m_deadline [SLOTS];
	logic [SLOT_W-1:0] bg_queue [$];
	logic [SLOT_W-1:0] dl_list [$];
	logic [31:0]       m_met, m_missed;

	out_t expected_results [$];
	int   errors = 0;
	int   cycles = 0;
	int   recv_idle = 0;
	bit   no_idle = 0;
	bit   hold_recv = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task automatic model_reset();
		m_clock = '0; m_run_slot = '0; m_run_valid = 0;
		for (int i = 0; i < SLOTS; i++) begin
			m_used[i] = 0; m_rt[i] = 0; m_release[i] = '0; m_deadline[i] = '0;
		end
		bg_queue.delete(); dl_list.delete();
		m_met = '0; m_missed = '0;
	endtask

	// sorted insert, equal deadlines keep arrival order
	function automatic void deadline_insert(input logic [SLOT_W-1:0] s);
		int pos;
		pos = 0;
		while (pos < dl_list.size() && m_deadline[dl_list[pos]] <= m_deadline[s])
			pos++;
		dl_list.insert(pos, s);
	endfunction

	function automatic bit pop_released(output logic [SLOT_W-1:0] s);
		s = '0;
		for (int i = 0; i < dl_list.size(); i++) begin
			if (m_release[dl_list[i]] <= m_clock) begin
				s = dl_list[i];
				dl_list.delete(i);
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic out_t schedule(input in_t req);
		out_t r;
		int free;
		logic [SLOT_W-1:0] fs, cur, pick;
		logic [TIME_W-1:0] earliest;
		bit got;
		r = '0;
		case (req.func)
			FN_TICK: m_clock = m_clock + 1;
			FN_BG, FN_RT: begin
				free = -1;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!m_used[i]) free = i;
				if (free < 0) begin
					r.status = STS_FULL;
				end else begin
					fs = SLOT_W'(free);
					m_used[fs] = 1;
					r.task_id = fs;
					if (req.func == FN_BG) begin
						m_rt[fs] = 0;
						bg_queue.push_back(fs);
					end else begin
						m_rt[fs] = 1;
						m_release[fs] = m_clock + req.start_offset_ms;
						m_deadline[fs] = m_release[fs] + req.relative_deadline_ms;
						deadline_insert(fs);
						r.task_is_realtime = 1;
					end
				end
			end
			default: begin
				cur = m_run_slot;
				if (m_run_valid) begin
					if (req.current_still_runnable) begin
						if (m_rt[cur]) deadline_insert(cur);
						else bg_queue.push_back(cur);
					end else begin
						if (m_rt[cur]) begin
							if (m_clock > m_deadline[cur]) m_missed++;
							else m_met++;
						end
						m_used[cur] = 0;
					end
				end
				m_run_valid = 0;
				got = 0;
				pick = '0;
				if (dl_list.size() == 0) begin
					if (bg_queue.size() != 0) begin
						pick = bg_queue.pop_front(); got = 1;
					end
				end else begin
					got = pop_released(pick);
					if (!got) begin
						if (bg_queue.size() != 0) begin
							pick = bg_queue.pop_front(); got = 1;
						end else begin
							earliest = m_release[dl_list[0]];
							foreach (dl_list[i])
								if (m_release[dl_list[i]] < earliest)
									earliest = m_release[dl_list[i]];
							if (m_clock < earliest) begin
								m_clock = earliest;
								r.waited = 1;
							end
							got = pop_released(pick);
						end
					end
				end
				if (got) begin
					m_run_slot = pick; m_run_valid = 1;
					r.task_id = pick; r.task_is_realtime = m_rt[pick];
				end else begin
					r.status = STS_NONE;
				end
			end
		endcase
		r.time_ms = m_clock;
		r.deadlines_met = m_met;
		r.deadlines_missed = m_missed;
		return r;
	endfunction

	// valid stays up between back-to-back requests; callers drop it before a pause
	task automatic send(input in_t req);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(schedule(req));
	endtask

	function automatic in_t make_req(input logic [1:0] f, input logic [31:0] off,
			input logic [31:0] rel, input logic run);
		in_t q;
		q.func = f; q.start_offset_ms = off; q.relative_deadline_ms = rel;
		q.current_still_runnable = run;
		return q;
	endfunction

	// random offsets mostly small so tasks release and deadlines both get hit
	function automatic logic [31:0] rand_time();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(0, 30);
		endcase
	endfunction

	function automatic in_t rand_req();
		int p;
		p = $urandom_range(0, 99);
		if (p < 25) return make_req(FN_TICK, $urandom(), $urandom(), $urandom_range(0, 1));
		if (p < 40) return make_req(FN_BG, $urandom(), $urandom(), $urandom_range(0, 1));
		if (p < 62) return make_req(FN_RT, rand_time(), rand_time(), $urandom_range(0, 1));
		return make_req(FN_SELECT, $urandom(), $urandom(), $urandom_range(0, 2) != 0);
	endfunction

	// directed table; check marks rows whose result is typed in
	typedef struct {
		in_t  req;
		bit   check;
		out_t want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	task automatic add_row(input in_t q, input bit c, input logic [1:0] st,
			input logic [3:0] id, input logic rt, input logic w, input logic [31:0] tm);
		dir_row_t d;
		d.req = q; d.check = c;
		d.want = '0;
		d.want.status = st; d.want.task_id = id; d.want.task_is_realtime = rt;
		d.want.waited = w; d.want.time_ms = tm;
		dir_rows.push_back(d);
	endtask

	// receiver, stalls come in random bursts
	always @(posedge clk) begin
		out_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					e = expected_results.pop_front();
					if (out_data.status !== e.status) report("status", out_data.status, e.status);
					if (out_data.task_id !== e.task_id) report("task_id", out_data.task_id, e.task_id);
					if (out_data.task_is_realtime !== e.task_is_realtime)
						report("task_is_realtime", out_data.task_is_realtime, e.task_is_realtime);
					if (out_data.waited !== e.waited) report("waited", out_data.waited, e.waited);
					if (out_data.time_ms !== e.time_ms) report("time_ms", out_data.time_ms, e.time_ms);
					if (out_data.deadlines_met !== e.deadlines_met)
						report("deadlines_met", out_data.deadlines_met, e.deadlines_met);
					if (out_data.deadlines_missed !== e.deadlines_missed)
						report("deadlines_missed", out_data.deadlines_missed, e.deadlines_missed);
				end
			end
			if (hold_recv) begin
				out_ready <= 1'b0;
			end else if (no_idle) begin
				recv_idle = 0;
				out_ready <= 1'b1;
			end else if (recv_idle > 0) begin
				recv_idle--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				recv_idle = $urandom_range(1, 5) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t d;
		out_t got_exp;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		model_reset();

		add_row(make_req(FN_SELECT, 0, 0, 1), 1, STS_NONE, 0, 0, 0, 0);
		add_row(make_req(FN_TICK, 0, 0, 0), 1, STS_DONE, 0, 0, 0, 1);
		add_row(make_req(FN_BG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 1, STS_DONE, 0, 0, 0, 1);
		add_row(make_req(FN_RT, 5, 0, 0), 1, STS_DONE, 1, 1, 0, 1);
		add_row(make_req(FN_RT, 5, 0, 0), 1, STS_DONE, 2, 1, 0, 1);
		add_row(make_req(FN_SELECT, 0, 0, 0), 1, STS_DONE, 0, 0, 0, 1);
		add_row(make_req(FN_SELECT, 0, 0, 0), 1, STS_DONE, 1, 1, 1, 6);
		add_row(make_req(FN_SELECT, 0, 0, 0), 0, STS_DONE, 0, 0, 0, 0);
		add_row(make_req(FN_SELECT, 0, 0, 0), 1, STS_NONE, 0, 0, 0, 6);
		add_row(make_req(FN_RT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 0, STS_DONE, 0, 0, 0, 0);
		add_row(make_req(FN_RT, 0, 0, 0), 0, STS_DONE, 0, 0, 0, 0);
		add_row(make_req(FN_SELECT, 0, 0, 1), 0, STS_DONE, 0, 0, 0, 0);
		add_row(make_req(FN_TICK, 0, 0, 1), 0, STS_DONE, 0, 0, 0, 0);
		add_row(make_req(FN_SELECT, 0, 0, 0), 0, STS_DONE, 0, 0, 0, 0);
		for (int i = 0; i < SLOTS + 1; i++)
			add_row(make_req(FN_BG, 0, 0, 0), (i >= SLOTS - 1), STS_FULL, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			d = dir_rows[i];
			send(d.req);
			got_exp = expected_results[$];
			if (d.check && (got_exp.status !== d.want.status ||
					(d.want.status != STS_FULL && (got_exp.task_id !== d.want.task_id ||
					got_exp.task_is_realtime !== d.want.task_is_realtime ||
					got_exp.waited !== d.want.waited || got_exp.time_ms !== d.want.time_ms))))
				report("directed row", i, 0);
		end

		// drain the table with finishing selects
		for (int i = 0; i < SLOTS + 2; i++)
			send(make_req(FN_SELECT, 0, 0, 0));
		in_valid <= 1'b0;

		// sender pauses until every expected result is in
		while (expected_results.size() != 0) @(posedge clk);

		// receiver holds off long while requests keep coming
		fork
			begin
				hold_recv = 1;
				repeat (200) @(posedge clk);
				hold_recv = 0;
			end
			for (int i = 0; i < 12; i++) send(rand_req());
		join

		for (int i = 0; i < RAND_REQS; i++) begin
			if (i == RAND_REQS - 80) no_idle = 1;
			send(rand_req());
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
